// ===== hdl/wopu_pkg.sv =====
// ---------------------------------------------------------------------------
// wopu_pkg
// Types and constants of the wheel odometry pose update: sequencer states,
// register map, field widths, CORDIC gain and arctangent table.
// ---------------------------------------------------------------------------
package wopu_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_GAIN,
      ST_SETUP,
      ST_ROTATE,
      ST_FINISH
   } state_type;

   // register map: index taken from csr_paddr[2]
   localparam logic REG_DIST_PER_TICK = 1'b0;
   localparam logic REG_TURN_GAIN     = 1'b1;
   localparam int   ADDR_W            = 3;
   localparam int   CSR_W             = 32;

   // field widths
   localparam int POS_W  = 48;
   localparam int HEAD_W = 32;
   localparam int CNT_W  = 5;
   localparam int ZW     = 34;

   // CORDIC limit gain 0.6072529 in Q32
   localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

   // atan(2^-i) in 2^-32 turn units, rounded to nearest
   function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         5'd24:   r = 32'd41;
         5'd25:   r = 32'd20;
         5'd26:   r = 32'd10;
         5'd27:   r = 32'd5;
         5'd28:   r = 32'd3;
         5'd29:   r = 32'd1;
         5'd30:   r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/wheel_odometry_pose_update.sv =====
// ---------------------------------------------------------------------------
// wheel_odometry_pose_update
// Dead-reckoning pose update for a four-wheel differential drive: tick
// deltas in, saturating x/y position and wrapping heading out.
// ---------------------------------------------------------------------------
// A transaction of four tick deltas passes through bit-serial shift-and-add
// multiplication for the travelled distance and the heading change (one bit
// of the register value per cycle), bit-serial scaling by the CORDIC gain,
// a set-up step, one CORDIC rotation step per cycle, and a commit of the
// pose. A new transaction is accepted while the previous result still waits
// on the output; the pose is only committed once that result has been
// taken. Registers dist_per_tick and turn_gain reset to zero, which leaves
// the pose at the origin.
module wheel_odometry_pose_update #(
   parameter int CORDIC_STEPS = 24,
   parameter int TICK_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // ticks_front_right, ticks_rear_right, ticks_front_left, ticks_rear_left
   input  logic [4*TICK_BITS-1:0]         req_tdata,
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pos_x [47:0], pos_y [95:48], heading [127:96]
   output logic [127:0]                   rsp_tdata,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [wopu_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [wopu_pkg::CSR_W-1:0]     csr_pwdata,
   output logic [wopu_pkg::CSR_W-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import wopu_pkg::*;

   localparam int SUM_W  = TICK_BITS + 2;
   localparam int MP_W   = SUM_W + 32;
   localparam int DIST_W = MP_W - 10;
   localparam int PW     = (TICK_BITS + 34 > 49) ? TICK_BITS + 34 : 49;
   localparam int CW     = DIST_W + 2;
   localparam int SW     = ((CW > POS_W) ? CW : POS_W) + 1;

   // configuration registers
   logic [31:0] dist_per_tick_ff;
   logic [31:0] turn_gain_ff;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // pose
   logic signed [POS_W-1:0] x_pos_ff, x_pos_in;
   logic signed [POS_W-1:0] y_pos_ff, y_pos_in;
   logic [HEAD_W-1:0]       heading_ff, heading_in;

   // datapath
   logic [SUM_W-1:0]        mag_ff, mag_in;
   logic                    sum_neg_ff, sum_neg_in;
   logic signed [SUM_W-1:0] diff_ff, diff_in;
   logic [31:0]             dpt_sr_ff, dpt_sr_in;
   logic [31:0]             tg_sr_ff, tg_sr_in;
   logic [MP_W-1:0]         mprod_ff, mprod_in;
   logic signed [PW-1:0]    pprod_ff, pprod_in;
   logic [DIST_W-1:0]       gacc_ff, gacc_in;
   logic signed [CW-1:0]    cx_ff, cx_in;
   logic signed [CW-1:0]    cy_ff, cy_in;
   logic signed [ZW-1:0]    z_ff, z_in;

   // input fields
   logic signed [TICK_BITS-1:0] ticks_fr, ticks_rr, ticks_fl, ticks_rl;
   logic signed [SUM_W-1:0]     tick_sum, tick_diff;
   logic                        req_fire, fin_fire, csr_write;

   assign ticks_fr = req_tdata[TICK_BITS-1:0];
   assign ticks_rr = req_tdata[2*TICK_BITS-1:TICK_BITS];
   assign ticks_fl = req_tdata[3*TICK_BITS-1:2*TICK_BITS];
   assign ticks_rl = req_tdata[4*TICK_BITS-1:3*TICK_BITS];

   assign tick_sum  = SUM_W'(ticks_fr) + SUM_W'(ticks_rr) + SUM_W'(ticks_fl) + SUM_W'(ticks_rl);
   assign tick_diff = (SUM_W'(ticks_fr) + SUM_W'(ticks_rr))
                    - (SUM_W'(ticks_fl) + SUM_W'(ticks_rl));

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign fin_fire   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TURN_GAIN) ? turn_gain_ff : dist_per_tick_ff;

   // result port shows the committed pose
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {heading_ff, y_pos_ff, x_pos_ff};

   // next state and datapath
   always_comb begin
      logic [DIST_W:0]         gsum;
      logic [HEAD_W-1:0]       target;
      logic [HEAD_W-1:0]       target_adj;
      logic                    flip;
      logic signed [CW-1:0]    e_val;
      logic signed [CW-1:0]    sx, sy;
      logic signed [SW-1:0]    xs, ys;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      x_pos_in     = x_pos_ff;
      y_pos_in     = y_pos_ff;
      heading_in   = heading_ff;
      mag_in       = mag_ff;
      sum_neg_in   = sum_neg_ff;
      diff_in      = diff_ff;
      dpt_sr_in    = dpt_sr_ff;
      tg_sr_in     = tg_sr_ff;
      mprod_in     = mprod_ff;
      pprod_in     = pprod_ff;
      gacc_in      = gacc_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;

      gsum       = {1'b0, gacc_ff} + (GAIN_Q32[cnt_ff] ? {1'b0, mprod_ff[MP_W-1:10]}
                                                      : {(DIST_W+1){1'b0}});
      target     = heading_ff + pprod_ff[48:17];
      flip       = target[31] ^ target[30];
      target_adj = {target[31] ^ flip, target[30:0]};
      e_val      = CW'(gacc_ff);
      sx         = cx_ff >>> cnt_ff;
      sy         = cy_ff >>> cnt_ff;
      xs         = SW'(x_pos_ff) + SW'(cx_ff);
      ys         = SW'(y_pos_ff) + SW'(cy_ff);

      unique case (state_ff)
         ST_IDLE: begin
            // capture tick sums and load the multiplier shift registers
            if (req_fire) begin
               sum_neg_in = tick_sum[SUM_W-1];
               mag_in     = tick_sum[SUM_W-1] ? SUM_W'(-tick_sum) : SUM_W'(tick_sum);
               diff_in    = tick_diff;
               dpt_sr_in  = dist_per_tick_ff;
               tg_sr_in   = turn_gain_ff;
               mprod_in   = '0;
               pprod_in   = '0;
               cnt_in     = '0;
               state_in   = ST_MULT;
            end
         end
         ST_MULT: begin
            // shift and add, one register bit per cycle, most significant first
            mprod_in  = (mprod_ff << 1) + (dpt_sr_ff[31] ? MP_W'(mag_ff) : MP_W'(0));
            pprod_in  = (pprod_ff <<< 1) + (tg_sr_ff[31] ? PW'(diff_ff) : PW'(0));
            dpt_sr_in = dpt_sr_ff << 1;
            tg_sr_in  = tg_sr_ff << 1;
            cnt_in    = cnt_ff + 1'b1;
            gacc_in   = '0;
            if (cnt_ff == CNT_W'(31)) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            // scale by the CORDIC gain, least significant bit first, drop one bit a cycle
            gacc_in = gsum[DIST_W:1];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(31)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // fold the rotation angle into the right half plane
            cx_in    = (sum_neg_ff ^ flip) ? -e_val : e_val;
            cy_in    = '0;
            z_in     = ZW'($signed(target_adj));
            cnt_in   = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            // one CORDIC micro-rotation per cycle
            if (!z_ff[ZW-1]) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               z_in  = z_ff - ZW'(atan_turn(cnt_ff));
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               z_in  = z_ff + ZW'(atan_turn(cnt_ff));
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // commit the pose once the output slot is free
            if (fin_fire) begin
               if (xs[SW-1:POS_W-1] == {(SW-POS_W+1){xs[SW-1]}}) begin
                  x_pos_in = xs[POS_W-1:0];
               end else begin
                  x_pos_in = {xs[SW-1], {(POS_W-1){~xs[SW-1]}}};
               end
               if (ys[SW-1:POS_W-1] == {(SW-POS_W+1){ys[SW-1]}}) begin
                  y_pos_in = ys[POS_W-1:0];
               end else begin
                  y_pos_in = {ys[SW-1], {(POS_W-1){~ys[SW-1]}}};
               end
               heading_in   = heading_ff + pprod_ff[47:16];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control, configuration and pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         dist_per_tick_ff <= '0;
         turn_gain_ff     <= '0;
         x_pos_ff         <= '0;
         y_pos_ff         <= '0;
         heading_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         x_pos_ff     <= x_pos_in;
         y_pos_ff     <= y_pos_in;
         heading_ff   <= heading_in;
         if (csr_write && csr_paddr[2] == REG_DIST_PER_TICK) begin
            dist_per_tick_ff <= csr_pwdata;
         end
         if (csr_write && csr_paddr[2] == REG_TURN_GAIN) begin
            turn_gain_ff <= csr_pwdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      sum_neg_ff <= sum_neg_in;
      diff_ff    <= diff_in;
      dpt_sr_ff  <= dpt_sr_in;
      tg_sr_ff   <= tg_sr_in;
      mprod_ff   <= mprod_in;
      pprod_ff   <= pprod_in;
      gacc_ff    <= gacc_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      z_ff       <= z_in;
   end

`ifndef NO_ASSERTIONS
   // an accepted transaction starts the multiply phase
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_MULT)
      else $error("accepted transaction did not start the multiply phase");

   // a result appears only straight after the commit cycle
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside the commit cycle");

   // a commit returns to idle with a result pending
   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("commit did not present a result");

   // the rotation step count never passes the configured length
   a_rotate_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROTATE |-> 32'(cnt_ff) < CORDIC_STEPS)
      else $error("CORDIC step count out of range");
`endif

endmodule
